// ===== sv/hot_cold_clock_cache_top_assert.svh =====
// Assertion macros for the hot/cold clock cache.
// Included by the top level; no other dependencies.
`ifndef HOT_COLD_CLOCK_CACHE_TOP_ASSERT_SVH
`define HOT_COLD_CLOCK_CACHE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HCC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HCC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HCC_ASSERT_IMP(name, clk, rst, ante, cons)
`define HCC_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/hcc_pkg.sv =====
// Shared types and constants for the hot/cold clock cache.
// No dependencies.
`timescale 1ns / 1ps
package hcc_pkg;
   localparam int ENTRIES_DEFAULT = 64;
   localparam int KEY_BITS_DEFAULT = 32;
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int CAP_BITS = 7;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;
   localparam int MISS_BITS = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DEMOTE,
      ST_SWEEP,
      ST_V0_ISSUE,
      ST_V0_TAKE,
      ST_SHIFT,
      ST_APPEND,
      ST_DONE
   } state_type;
endpackage

// ===== sv/hcc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module hcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/hot_cold_clock_cache_top.sv =====
// Top level of the hot/cold clock cache: control sequencer around one entry RAM.
// Depends on hcc_pkg, hcc_ram and hot_cold_clock_cache_top_assert.svh.
//
// Usage: a request (req_mode, req_key, req_write_value) is taken on req_valid and
// req_ready; one response (hit, read value, eviction, miss total) leaves on
// rsp_valid and rsp_ready. The user must write the capacity register on csr_valid
// only while the block is idle; the block does not enforce it. csr_ready is always high.
// Entries live in one RAM ordered by age, one entry read per cycle. A request
// takes a lookup scan over the used entries, plus a hot demotion scan after a
// hit that makes too many entries hot. A put that misses into a full cache adds
// up to two sweep passes, a read to take the oldest entry, a compaction pass and
// one append step. The single RAM read port sets the length of these passes.
// One request is in work at a time; the next one is taken as soon as the
// previous response is in the output register, even while it waits.
// If the receiver stalls, the finished request waits in its last state until
// the output register frees up. Reset empties the cache, clears the miss
// counter and sets the capacity to 64; no clearing pass is needed.
`timescale 1ns / 1ps
`include "hot_cold_clock_cache_top_assert.svh"
module hot_cold_clock_cache_top #(
   parameter int ENTRIES = hcc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = hcc_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = hcc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [VALUE_BITS-1:0]         req_write_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [VALUE_BITS-1:0]         rsp_read_value,
   output logic                          rsp_evicted,
   output logic [KEY_BITS-1:0]           rsp_evicted_key,
   output logic [hcc_pkg::MISS_BITS-1:0] rsp_miss_total,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hcc_pkg::CAP_BITS-1:0]  csr_capacity_limit
);
   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int CMPW = (CW > hcc_pkg::CAP_BITS) ? CW : hcc_pkg::CAP_BITS;
   localparam int W = KEY_BITS + VALUE_BITS + 2;
   localparam logic [hcc_pkg::MISS_BITS-1:0] MISS_MAX = '1;

   hcc_pkg::state_type state_ff, state_in;
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic pv_ff, pv_in;
   logic [AW-1:0] pp_ff, pp_in;
   logic wrap_ff, wrap_in;
   logic mode_ff, mode_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CW-1:0] hot_ff, hot_in, cold_ff, cold_in;
   logic [hcc_pkg::MISS_BITS-1:0] miss_ff, miss_in;
   logic [hcc_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic hit_ff, hit_in;
   logic [VALUE_BITS-1:0] rdv_ff, rdv_in;
   logic ev_ff, ev_in;
   logic [KEY_BITS-1:0] evk_ff, evk_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic [VALUE_BITS-1:0] rsp_rdv_ff, rsp_rdv_in;
   logic rsp_ev_ff, rsp_ev_in;
   logic [KEY_BITS-1:0] rsp_evk_ff, rsp_evk_in;
   logic [hcc_pkg::MISS_BITS-1:0] rsp_miss_ff, rsp_miss_in;

   logic ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [W-1:0] ram_wdata, ram_rdata;

   logic [CW-1:0] used;
   logic [CMPW-1:0] cap_ext, eff_cap, hot_limit;
   logic [KEY_BITS-1:0] r_key;
   logic [VALUE_BITS-1:0] r_data;
   logic r_hot, r_ref;
   logic issue_ok, scan_end;

   hcc_ram #(
      .WIDTH(W),
      .DEPTH(ENTRIES)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en(ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign used = hot_ff + cold_ff;
   assign cap_ext = CMPW'(cap_ff);
   assign r_key = ram_rdata[W-1 -: KEY_BITS];
   assign r_data = ram_rdata[VALUE_BITS+1:2];
   assign r_hot = ram_rdata[1];
   assign r_ref = ram_rdata[0];

   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMPW'(1);
      end else if (cap_ext > CMPW'(ENTRIES)) begin
         eff_cap = CMPW'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      hot_limit = eff_cap >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcc_pkg::ST_IDLE;
         pv_ff <= 1'b0;
         hot_ff <= '0;
         cold_ff <= '0;
         miss_ff <= '0;
         cap_ff <= hcc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff <= pv_in;
         hot_ff <= hot_in;
         cold_ff <= cold_in;
         miss_ff <= miss_in;
         cap_ff <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_cnt_ff <= rd_cnt_in;
      pp_ff <= pp_in;
      wrap_ff <= wrap_in;
      mode_ff <= mode_in;
      key_ff <= key_in;
      val_ff <= val_in;
      hit_ff <= hit_in;
      rdv_ff <= rdv_in;
      ev_ff <= ev_in;
      evk_ff <= evk_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_rdv_ff <= rsp_rdv_in;
      rsp_ev_ff <= rsp_ev_in;
      rsp_evk_ff <= rsp_evk_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   always_comb begin
      state_in = state_ff;
      rd_cnt_in = rd_cnt_ff;
      pv_in = 1'b0;
      pp_in = pp_ff;
      wrap_in = wrap_ff;
      mode_in = mode_ff;
      key_in = key_ff;
      val_in = val_ff;
      hot_in = hot_ff;
      cold_in = cold_ff;
      miss_in = miss_ff;
      cap_in = cap_ff;
      hit_in = hit_ff;
      rdv_in = rdv_ff;
      ev_in = ev_ff;
      evk_in = evk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in = rsp_hit_ff;
      rsp_rdv_in = rsp_rdv_ff;
      rsp_ev_in = rsp_ev_ff;
      rsp_evk_in = rsp_evk_ff;
      rsp_miss_in = rsp_miss_ff;
      ram_we = 1'b0;
      ram_waddr = pp_ff;
      ram_wdata = ram_rdata;
      ram_re = 1'b0;
      ram_raddr = rd_cnt_ff[AW-1:0];
      req_ready = 1'b0;

      if (state_ff == hcc_pkg::ST_SHIFT) begin
         issue_ok = rd_cnt_ff <= used;
      end else begin
         issue_ok = rd_cnt_ff < used;
      end
      scan_end = !pv_ff && !issue_ok;

      if (csr_valid) begin
         cap_in = csr_capacity_limit;
      end

      if ((state_ff == hcc_pkg::ST_SEARCH || state_ff == hcc_pkg::ST_DEMOTE ||
           state_ff == hcc_pkg::ST_SWEEP || state_ff == hcc_pkg::ST_SHIFT) && issue_ok) begin
         ram_re = 1'b1;
         rd_cnt_in = rd_cnt_ff + 1'b1;
         pv_in = 1'b1;
         pp_in = rd_cnt_ff[AW-1:0];
      end

      case (state_ff)
         hcc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in = req_mode;
               key_in = req_key;
               val_in = req_write_value;
               hit_in = 1'b0;
               rdv_in = '0;
               ev_in = 1'b0;
               evk_in = '0;
               rd_cnt_in = '0;
               state_in = hcc_pkg::ST_SEARCH;
            end
         end
         hcc_pkg::ST_SEARCH: begin
            if (pv_ff && r_key == key_ff) begin
               ram_we = 1'b1;
               ram_wdata = {r_key, (mode_ff ? val_ff : r_data), 1'b1, 1'b1};
               hit_in = 1'b1;
               rdv_in = mode_ff ? '0 : r_data;
               pv_in = 1'b0;
               state_in = hcc_pkg::ST_DONE;
               if (!r_hot) begin
                  hot_in = hot_ff + 1'b1;
                  cold_in = cold_ff - 1'b1;
                  if (CMPW'(hot_ff + 1'b1) > hot_limit) begin
                     rd_cnt_in = '0;
                     state_in = hcc_pkg::ST_DEMOTE;
                  end
               end
            end else if (scan_end) begin
               if (miss_ff != MISS_MAX) begin
                  miss_in = miss_ff + 1'b1;
               end
               if (!mode_ff) begin
                  state_in = hcc_pkg::ST_DONE;
               end else if (CMPW'(used) >= eff_cap) begin
                  rd_cnt_in = '0;
                  wrap_in = 1'b0;
                  state_in = hcc_pkg::ST_SWEEP;
               end else begin
                  state_in = hcc_pkg::ST_APPEND;
               end
            end
         end
         hcc_pkg::ST_DEMOTE: begin
            if (pv_ff && r_hot) begin
               ram_we = 1'b1;
               ram_wdata = {r_key, r_data, 1'b0, r_ref};
               hot_in = hot_ff - 1'b1;
               cold_in = cold_ff + 1'b1;
               if (CMPW'(hot_ff - 1'b1) <= hot_limit) begin
                  pv_in = 1'b0;
                  state_in = hcc_pkg::ST_DONE;
               end
            end else if (scan_end) begin
               state_in = hcc_pkg::ST_DONE;
            end
         end
         hcc_pkg::ST_SWEEP: begin
            if (pv_ff && !r_hot) begin
               if (r_ref) begin
                  ram_we = 1'b1;
                  ram_wdata = {r_key, r_data, 1'b0, 1'b0};
               end else begin
                  ev_in = 1'b1;
                  evk_in = r_key;
                  cold_in = cold_ff - 1'b1;
                  pv_in = 1'b0;
                  rd_cnt_in = CW'(pp_ff) + 1'b1;
                  state_in = hcc_pkg::ST_SHIFT;
               end
            end else if (scan_end) begin
               if (!wrap_ff) begin
                  wrap_in = 1'b1;
                  rd_cnt_in = '0;
               end else begin
                  state_in = hcc_pkg::ST_V0_ISSUE;
               end
            end
         end
         hcc_pkg::ST_V0_ISSUE: begin
            ram_re = 1'b1;
            ram_raddr = '0;
            state_in = hcc_pkg::ST_V0_TAKE;
         end
         hcc_pkg::ST_V0_TAKE: begin
            ev_in = 1'b1;
            evk_in = r_key;
            if (r_hot) begin
               hot_in = hot_ff - 1'b1;
            end else begin
               cold_in = cold_ff - 1'b1;
            end
            rd_cnt_in = CW'(1);
            state_in = hcc_pkg::ST_SHIFT;
         end
         hcc_pkg::ST_SHIFT: begin
            if (pv_ff) begin
               ram_we = 1'b1;
               ram_waddr = pp_ff - 1'b1;
               ram_wdata = ram_rdata;
            end else if (scan_end) begin
               state_in = hcc_pkg::ST_APPEND;
            end
         end
         hcc_pkg::ST_APPEND: begin
            ram_we = 1'b1;
            ram_waddr = used[AW-1:0];
            ram_wdata = {key_ff, val_ff, 1'b0, 1'b1};
            cold_in = cold_ff + 1'b1;
            state_in = hcc_pkg::ST_DONE;
         end
         hcc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in = hit_ff;
               rsp_rdv_in = rdv_ff;
               rsp_ev_in = ev_ff;
               rsp_evk_in = evk_ff;
               rsp_miss_in = miss_ff;
               state_in = hcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hcc_pkg::ST_IDLE;
         end
      endcase
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_read_value = rsp_rdv_ff;
   assign rsp_evicted = rsp_ev_ff;
   assign rsp_evicted_key = rsp_evk_ff;
   assign rsp_miss_total = rsp_miss_ff;

   `HCC_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used <= CW'(ENTRIES))
   `HCC_ASSERT_NXT(a_done_loads, clock, reset,
      state_ff == hcc_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff)
   `HCC_ASSERT_NXT(a_append_grows, clock, reset,
      state_ff == hcc_pkg::ST_APPEND, cold_ff == $past(cold_ff) + 1'b1)
   `HCC_ASSERT_IMP(a_evict_on_put, clock, reset, rsp_valid_ff && rsp_ev_ff, !rsp_hit_ff)
endmodule

// ===== tb/hot_cold_clock_cache_top_tb.sv =====
// Self-checking testbench for the hot/cold clock cache top level.
// It predicts every response in a behavioral cache model and compares it.
// Depends on hcc_pkg and the hot_cold_clock_cache_top RTL.
`timescale 1ns / 1ps
module hot_cold_clock_cache_top_tb;
   localparam int SLOTS = 64;
   localparam int DRAIN_CYCLES = 4 * SLOTS + 40;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int CAPW = hcc_pkg::CAP_BITS;

   typedef struct {
      logic        mode;
      logic [31:0] key;
      logic [31:0] value;
   } request_type;

   typedef struct {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
      logic [31:0] miss_total;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   logic [31:0] req_key = '0;
   logic [31:0] req_write_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic [31:0] rsp_read_value;
   logic rsp_evicted;
   logic [31:0] rsp_evicted_key;
   logic [hcc_pkg::MISS_BITS-1:0] rsp_miss_total;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [hcc_pkg::CAP_BITS-1:0] csr_capacity_limit = hcc_pkg::CAP_RESET;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int quiet_cycles = 0;
   int failures = 0;

   // Cache state as the block should hold it.
   logic        slot_valid[SLOTS];
   logic [31:0] slot_key[SLOTS];
   logic [31:0] slot_data[SLOTS];
   logic        slot_hot[SLOTS];
   logic        slot_ref[SLOTS];
   int          age_list[$];
   int          hot_total = 0;
   int          cold_total = 0;
   logic [31:0] miss_tally = '0;
   logic [hcc_pkg::CAP_BITS-1:0] capacity_reg = hcc_pkg::CAP_RESET;

   hot_cold_clock_cache_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_key(req_key), .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value), .rsp_evicted(rsp_evicted),
      .rsp_evicted_key(rsp_evicted_key), .rsp_miss_total(rsp_miss_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_capacity_limit(csr_capacity_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int effective_capacity();
      int c;
      c = capacity_reg;
      if (c < 1) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
   endfunction

   function automatic void demote_excess_hot();
      bit found;
      while (hot_total > effective_capacity() / 2) begin
         found = 0;
         foreach (age_list[p]) begin
            if (!found && slot_hot[age_list[p]]) begin
               slot_hot[age_list[p]] = 1'b0;
               hot_total--;
               cold_total++;
               found = 1;
            end
         end
         if (!found) break;
      end
   endfunction

   function automatic int pick_victim();
      foreach (age_list[p]) begin
         if (!slot_hot[age_list[p]]) begin
            if (slot_ref[age_list[p]]) slot_ref[age_list[p]] = 1'b0;
            else return p;
         end
      end
      foreach (age_list[p])
         if (!slot_hot[age_list[p]]) return p;
      return 0;
   endfunction

   function automatic response_type cache_access(request_type r);
      response_type res;
      int pos;
      int s;
      int vp;
      res = '{1'b0, 32'd0, 1'b0, 32'd0, 32'd0};
      pos = -1;
      foreach (age_list[p])
         if (pos < 0 && slot_valid[age_list[p]] && slot_key[age_list[p]] == r.key) pos = p;
      if (pos >= 0) begin
         s = age_list[pos];
         res.hit = 1'b1;
         slot_ref[s] = 1'b1;
         if (r.mode) slot_data[s] = r.value;
         else res.read_value = slot_data[s];
         if (!slot_hot[s]) begin
            slot_hot[s] = 1'b1;
            hot_total++;
            cold_total--;
            demote_excess_hot();
         end
      end else begin
         if (miss_tally != 32'hFFFF_FFFF) miss_tally++;
         if (r.mode) begin
            if (age_list.size() >= effective_capacity()) begin
               vp = pick_victim();
               s = age_list[vp];
               res.evicted = 1'b1;
               res.evicted_key = slot_key[s];
               slot_valid[s] = 1'b0;
               if (slot_hot[s]) hot_total--; else cold_total--;
               age_list.delete(vp);
            end
            s = 0;
            while (s < SLOTS && slot_valid[s]) s++;
            if (s < SLOTS) begin
               slot_valid[s] = 1'b1;
               slot_key[s] = r.key;
               slot_data[s] = r.value;
               slot_hot[s] = 1'b0;
               slot_ref[s] = 1'b1;
               age_list.push_back(s);
               cold_total++;
            end
         end
      end
      res.miss_total = miss_tally;
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         failures++;
      end
   endfunction

   // Request driver; the expectation is formed when the block takes a request.
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready)
            expected_responses.push_back(cache_access('{req_mode, req_key, req_write_value}));
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            r = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_mode <= r.mode;
            req_key <= r.key;
            req_write_value <= r.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor and receiver stalls.
   always @(posedge clock) begin
      response_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               e = expected_responses.pop_front();
               check_field("hit", e.hit, rsp_hit);
               check_field("read_value", e.read_value, rsp_read_value);
               check_field("evicted", e.evicted, rsp_evicted);
               check_field("evicted_key", e.evicted_key, rsp_evicted_key);
               check_field("miss_total", e.miss_total, rsp_miss_total);
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL hot_cold_clock_cache_top");
         $finish;
      end
   end

   task automatic drain();
      while (pending_requests.size() > 0 || expected_responses.size() > 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [hcc_pkg::CAP_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_capacity_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      capacity_reg = value;
   endtask

   task automatic add_request(logic mode, logic [31:0] key, logic [31:0] value);
      pending_requests.push_back('{mode, key, value});
   endtask

   task automatic random_requests(int count, int pool_size);
      logic [31:0] pool[];
      pool = new[pool_size];
      foreach (pool[i]) pool[i] = $urandom;
      repeat (count) begin
         if ($urandom_range(9) == 0)
            add_request(1'($urandom_range(1)), $urandom, $urandom);
         else
            add_request(1'($urandom_range(1)), pool[$urandom_range(pool_size - 1)], $urandom);
      end
   endtask

   initial begin
      int caps[10];
      int idle_send[4];
      int idle_recv[4];
      caps = '{1, 0, 127, 2, 3, 8, 64, 4, 16, 64};
      idle_send = '{0, 73, 0, 15};
      idle_recv = '{0, 0, 73, 15};
      foreach (slot_valid[i]) begin
         slot_valid[i] = 1'b0;
         slot_hot[i] = 1'b0;
         slot_ref[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_request(1'b0, 32'h0000_0000, 32'h0);
      add_request(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      add_request(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      add_request(1'b0, 32'h0000_0000, 32'h1234_5678);
      add_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(1'b1, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
      add_request(1'b0, 32'hFFFF_FFFF, 32'h0);
      add_request(1'b0, 32'h5555_AAAA, 32'h0);
      add_request(1'b1, 32'hAAAA_5555, 32'h5555_AAAA);
      add_request(1'b0, 32'hAAAA_5555, 32'h0);
      drain();
      write_capacity(7'd2);
      add_request(1'b1, 32'h1, 32'h11);
      add_request(1'b1, 32'h2, 32'h22);
      add_request(1'b0, 32'h1, 32'h0);
      add_request(1'b0, 32'h2, 32'h0);
      add_request(1'b1, 32'h3, 32'h33);
      add_request(1'b1, 32'h4, 32'h44);
      add_request(1'b0, 32'h3, 32'h0);
      add_request(1'b1, 32'h5, 32'h55);

      for (int ph = 0; ph < 10; ph++) begin
         drain();
         write_capacity(CAPW'(caps[ph]));
         send_idle_pct = idle_send[ph % 4];
         recv_stall_pct = idle_recv[ph % 4];
         if (ph == 5) hold_off_cycles = 800;
         random_requests(172, (effective_capacity() * 3) / 2 + 2);
      end
      drain();
      if (failures == 0)
         $display("PASS hot_cold_clock_cache_top");
      else
         $display("FAIL hot_cold_clock_cache_top");
      $finish;
   end
endmodule

// ===== hot_cold_clock_cache_top.f =====
+incdir+sv
sv/hcc_pkg.sv
sv/hcc_ram.sv
sv/hot_cold_clock_cache_top.sv
tb/hot_cold_clock_cache_top_tb.sv
